[sv/pcla_pkg.sv]
// Shared constants and types for the press-count code lock with alarm.
`default_nettype none

package pcla_pkg;

   // Code geometry and counting limits
   localparam int unsigned CODE_DIGITS   = 3;
   localparam int unsigned DIGIT_W       = 4;
   localparam int unsigned INDEX_W       = 2;
   localparam int unsigned TIME_W        = 32;
   localparam int unsigned CSR_INDEX_W   = 3;
   localparam int unsigned CSR_DATA_W    = 16;

   localparam logic [DIGIT_W-1:0] COUNT_LIMIT   = 4'd10;
   localparam logic [TIME_W-1:0]  DEADLINE_IDLE = 32'hFFFF_FFFF;

   // Register reset values
   localparam logic [15:0]        DEBOUNCE_RESET = 16'd20;
   localparam logic [15:0]        TIMEOUT_RESET  = 16'd100;
   localparam logic [7:0]         PERIOD_RESET   = 8'd10;
   localparam logic [DIGIT_W-1:0] SECRET_RESET   = 4'd1;

   // Register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEBOUNCE      = 3'd0,
      CSR_DIGIT_TIMEOUT = 3'd1,
      CSR_STEP_PERIOD   = 3'd2,
      CSR_SECRET_FIRST  = 3'd3,
      CSR_SECRET_SECOND = 3'd4,
      CSR_SECRET_THIRD  = 3'd5
   } csr_index_type;

   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

`default_nettype wire

[sv/press_count_code_lock_alarm.sv]
// Top level of the press-count code lock: debounce, digit entry, arming and alarm LED.
//
//  channel | ports                                  | direction | handshake
//  --------+----------------------------------------+-----------+----------------------
//  req     | req_code_edge, req_presence_edge       | in        | req_valid / req_ready
//  rsp     | rsp_armed, rsp_alarm_led, rsp_digit_*, | out       | rsp_valid / rsp_ready
//          | rsp_code_accepted, rsp_code_rejected   |           |
//  csr     | csr_write_en, csr_index, csr_wdata     | in        | write enable only
//
//  One item per cycle sustained while rsp_ready is high; each item passes the input register, then the result register.
//  The full tick update (debounce, rules, period counter) is combinational on the state regs.
//  Reset is synchronous; it restores config, state and valid registers, not the item data.
//  With rsp_ready low the result holds, one more item parks in the input register,
//  and then req_ready drops until the result is taken.
`default_nettype none

module press_count_code_lock_alarm (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input items (one per tick)
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_code_edge,
   input  wire logic                                 req_presence_edge,
   // result items
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_armed,
   output logic                                      rsp_alarm_led,
   output logic                                      rsp_digit_advance_pulse,
   output logic                                      rsp_code_accepted,
   output logic                                      rsp_code_rejected,
   // register writes
   input  wire logic                                 csr_write_en,
   input  wire logic [pcla_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [pcla_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned TW = pcla_pkg::TIME_W;
   localparam int unsigned IW = pcla_pkg::INDEX_W;

   // Configuration registers
   logic [15:0]         debounce_ff;
   logic [15:0]         timeout_ff;
   logic [7:0]          period_ff;
   pcla_pkg::digit_type secret_ff [pcla_pkg::CODE_DIGITS];

   // Input register
   logic in_valid_ff;
   logic in_code_ff;
   logic in_pres_ff;
   logic s1_move;

   // Lock state
   logic [TW-1:0]       tick_ff,     tick_in;
   logic [TW-1:0]       block_ff,    block_in;
   logic [TW-1:0]       deadline_ff, deadline_in;
   logic [7:0]          pcount_ff,   pcount_in;
   logic                press_ff,    press_in;
   logic                pres_ff,     pres_in;
   logic                started_ff,  started_in;
   logic [IW-1:0]       index_ff,    index_in;
   pcla_pkg::digit_type counts_ff [pcla_pkg::CODE_DIGITS];
   pcla_pkg::digit_type counts_in [pcla_pkg::CODE_DIGITS];
   logic                armed_ff,    armed_in;
   logic                led_ff,      led_in;

   // Per-item results
   logic                pulse_in;
   logic                accept_in;
   logic                reject_in;

   // Output register
   logic rsp_valid_ff;
   logic rsp_armed_ff, rsp_led_ff, rsp_pulse_ff, rsp_accept_ff, rsp_reject_ff;

   // Helpers
   logic                full;
   logic                code_match;
   pcla_pkg::digit_type cur_count;
   logic [7:0]          period_eff;
   logic [8:0]          pcount_sum;

   // Handshake: input register drains into the result register
   assign s1_move   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         in_code_ff <= req_code_edge;
         in_pres_ff <= req_presence_edge;
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= pcla_pkg::DEBOUNCE_RESET;
         timeout_ff  <= pcla_pkg::TIMEOUT_RESET;
         period_ff   <= pcla_pkg::PERIOD_RESET;
         for (int i = 0; i < pcla_pkg::CODE_DIGITS; i++) begin
            secret_ff[i] <= pcla_pkg::SECRET_RESET;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            pcla_pkg::CSR_DEBOUNCE:      debounce_ff  <= csr_wdata;
            pcla_pkg::CSR_DIGIT_TIMEOUT: timeout_ff   <= csr_wdata;
            pcla_pkg::CSR_STEP_PERIOD:   period_ff    <= csr_wdata[7:0];
            pcla_pkg::CSR_SECRET_FIRST:  secret_ff[0] <= csr_wdata[3:0];
            pcla_pkg::CSR_SECRET_SECOND: secret_ff[1] <= csr_wdata[3:0];
            pcla_pkg::CSR_SECRET_THIRD:  secret_ff[2] <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Count of the digit being entered; no digit once all are in
   always_comb begin
      case (index_ff)
         2'd0:    cur_count = counts_ff[0];
         2'd1:    cur_count = counts_ff[1];
         2'd2:    cur_count = counts_ff[2];
         default: cur_count = '0;
      endcase
   end

   assign full       = (index_ff == IW'(pcla_pkg::CODE_DIGITS));
   assign code_match = (counts_ff[0] == secret_ff[0]) && (counts_ff[1] == secret_ff[1])
                    && (counts_ff[2] == secret_ff[2]);

   // One tick: edges first, then the rules on period boundaries
   always_comb begin
      block_in    = block_ff;
      press_in    = press_ff;
      pres_in     = pres_ff;
      started_in  = started_ff;
      deadline_in = deadline_ff;
      index_in    = index_ff;
      armed_in    = armed_ff;
      led_in      = led_ff;
      pulse_in    = 1'b0;
      accept_in   = 1'b0;
      reject_in   = 1'b0;
      for (int i = 0; i < pcla_pkg::CODE_DIGITS; i++) begin
         counts_in[i] = counts_ff[i];
      end

      // debounce: every edge restarts the shared window
      if (in_code_ff) begin
         if (tick_ff > block_in) begin
            press_in   = 1'b1;
            started_in = 1'b1;
         end
         block_in = tick_ff + TW'(debounce_ff);
      end
      if (in_pres_ff) begin
         if (tick_ff > block_in) begin
            pres_in = 1'b1;
         end
         block_in = tick_ff + TW'(debounce_ff);
      end

      // first matching rule acts
      if (pcount_ff == 8'd0) begin
         if (!full && press_in && (cur_count <= pcla_pkg::COUNT_LIMIT)) begin
            press_in            = 1'b0;
            counts_in[index_ff] = cur_count + 4'd1;
            deadline_in         = tick_ff + TW'(timeout_ff);
         end else if (started_in && (deadline_ff <= tick_ff)) begin
            pulse_in = 1'b1;
            if (!full) begin
               index_in = index_ff + 2'd1;
            end
            deadline_in = pcla_pkg::DEADLINE_IDLE;
         end else if (full) begin
            if (code_match) begin
               accept_in = 1'b1;
               armed_in  = !armed_ff;
            end else begin
               reject_in = 1'b1;
            end
            for (int i = 0; i < pcla_pkg::CODE_DIGITS; i++) begin
               counts_in[i] = '0;
            end
            led_in     = 1'b0;
            index_in   = '0;
            started_in = 1'b0;
            press_in   = 1'b0;
            pres_in    = 1'b0;
         end else if (armed_ff && pres_in) begin
            led_in = 1'b1;
         end
      end

      // period counter, a zero period acts as one
      period_eff = (period_ff == 8'd0) ? 8'd1 : period_ff;
      pcount_sum = {1'b0, pcount_ff} + 9'd1;
      pcount_in  = (pcount_sum >= {1'b0, period_eff}) ? 8'd0 : pcount_sum[7:0];
      tick_in    = tick_ff + TW'(1);
   end

   // State update, one tick per moved item
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         block_ff    <= '0;
         deadline_ff <= '0;
         pcount_ff   <= '0;
         press_ff    <= 1'b0;
         pres_ff     <= 1'b0;
         started_ff  <= 1'b0;
         index_ff    <= '0;
         armed_ff    <= 1'b0;
         led_ff      <= 1'b0;
         for (int i = 0; i < pcla_pkg::CODE_DIGITS; i++) begin
            counts_ff[i] <= '0;
         end
      end else if (s1_move) begin
         tick_ff     <= tick_in;
         block_ff    <= block_in;
         deadline_ff <= deadline_in;
         pcount_ff   <= pcount_in;
         press_ff    <= press_in;
         pres_ff     <= pres_in;
         started_ff  <= started_in;
         index_ff    <= index_in;
         armed_ff    <= armed_in;
         led_ff      <= led_in;
         for (int i = 0; i < pcla_pkg::CODE_DIGITS; i++) begin
            counts_ff[i] <= counts_in[i];
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_move) begin
         rsp_armed_ff  <= armed_in;
         rsp_led_ff    <= led_in;
         rsp_pulse_ff  <= pulse_in;
         rsp_accept_ff <= accept_in;
         rsp_reject_ff <= reject_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_armed               = rsp_armed_ff;
   assign rsp_alarm_led           = rsp_led_ff;
   assign rsp_digit_advance_pulse = rsp_pulse_ff;
   assign rsp_code_accepted       = rsp_accept_ff;
   assign rsp_code_rejected       = rsp_reject_ff;

   // Checks
   // at most one rule acts per tick
   a_one_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_pulse_ff, rsp_accept_ff, rsp_reject_ff}))
      else $error("more than one rule acted in one tick");

   // an accepted code flips armed
   a_accept_toggles: assert property (@(posedge clock) disable iff (reset)
      (s1_move && accept_in) |=> (armed_ff != $past(armed_ff)))
      else $error("accepted code did not toggle armed");

   // the LED can only be lit while armed
   a_led_needs_armed: assert property (@(posedge clock) disable iff (reset)
      led_ff |-> armed_ff)
      else $error("alarm LED lit while disarmed");

   // no entry in progress means nothing counted and nothing pending
   a_idle_entry_clear: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (!press_ff && (counts_ff[0] == '0) && (counts_ff[1] == '0)
                       && (counts_ff[2] == '0)))
      else $error("digit counts present without an entry in progress");

endmodule

`default_nettype wire
